// ----- src/bbhq_pkg.sv -----
// Shared types, constants and codes for the byte budgeted history queue.
package bbhq_pkg;

  localparam int HISTORY_DEPTH = 64;
  localparam int SIZE_BITS     = 32;
  localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
  localparam int COUNT_W       = $clog2(HISTORY_DEPTH + 1);

  localparam int MODE_W    = 2;
  localparam int BYTES_W   = 32;
  localparam int POS_W     = 6;
  localparam int LIMIT_W   = 7;
  localparam int TOTAL_W   = 38;
  localparam int CFG_IDX_W = 1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(64);
  localparam logic [TOTAL_W-1:0] BUDGET_RESET = TOTAL_W'(64'd274877906880);

  typedef enum logic [MODE_W-1:0] {
    MODE_CAPTURE  = 2'd0,
    MODE_TRUNCATE = 2'd1,
    MODE_CHECK    = 2'd2,
    MODE_APPLY    = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTRY_LIMIT = 1'b0,
    REG_BYTE_BUDGET = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ALU_SUM_CMP,
    ALU_ADD_SAT,
    ALU_SUB_FLOOR
  } alu_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FORECAST,
    ST_FC_LATCH,
    ST_CAP_BUDGET,
    ST_CAP_LIMIT,
    ST_APPEND,
    ST_ENF_LIMIT,
    ST_ENF_BUDGET,
    ST_TRUNC,
    ST_DROP,
    ST_DONE
  } state_e;

  typedef struct packed {
    mode_e               mode;
    logic [BYTES_W-1:0]  entry_bytes;
    logic [POS_W-1:0]    position;
  } cmd_t;

  typedef struct packed {
    logic [POS_W-1:0]    new_position;
    logic                ok;
    logic [LIMIT_W-1:0]  entry_count;
    logic [TOTAL_W-1:0]  byte_total;
  } result_t;

  typedef struct packed {
    logic [TOTAL_W-1:0]  value;
    logic                over;
  } alu_res_t;

endpackage

// ----- src/byte_budgeted_history_queue.sv -----
// Top level of the byte budgeted history queue: sequencer, size ring and totals.
//
//   channel   direction  handshake              payload
//   command   in         start_i / busy_o       cmd_i     (bbhq_pkg::cmd_t)
//   result    out        done_o strobe          result_o  (bbhq_pkg::result_t)
//   config    in         cfg_we_i, cfg_idx_i    cfg_data_i (38 bits)
//
// Handshake: a word is taken when start_i is high and busy_o is low; busy_o then
//   stays high until the result strobe. Every entry dropped costs one ring read and
//   one pass through the shared adder, since the ring has a single registered read
//   port and there is only the one adder.
// Reset: counts, totals and slot pointer clear; the size ring is not cleared and
//   only ever read where it was written.
// Stalls: the receiver cannot stall; done_o is high for exactly one cycle.
module byte_budgeted_history_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  bbhq_pkg::cmd_t                      cmd_i,
  output logic                                done_o,
  output bbhq_pkg::result_t                   result_o,
  input  logic                                cfg_we_i,
  input  logic [bbhq_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bbhq_pkg::TOTAL_W-1:0]        cfg_data_i
);

  // Configuration registers
  logic [bbhq_pkg::LIMIT_W-1:0]   limit_q;
  logic [bbhq_pkg::TOTAL_W-1:0]   budget_q;

  // Sequencer and bookkeeping state
  bbhq_pkg::state_e               state_q, state_d;
  bbhq_pkg::state_e               ret_q, ret_d;
  logic [bbhq_pkg::SLOT_W-1:0]    oldest_q, oldest_d;
  logic [bbhq_pkg::COUNT_W-1:0]   held_q, held_d;
  logic [bbhq_pkg::TOTAL_W-1:0]   total_q, total_d;
  logic [bbhq_pkg::TOTAL_W-1:0]   forecast_q, forecast_d;
  logic                           done_q, done_d;
  bbhq_pkg::result_t              res_q, res_d;
  bbhq_pkg::cmd_t                 cmd_q;

  // Size ring: one write, one registered read per cycle
  logic [bbhq_pkg::SIZE_BITS-1:0] ring_q [bbhq_pkg::HISTORY_DEPTH];
  logic [bbhq_pkg::SIZE_BITS-1:0] rd_data_q;
  logic [bbhq_pkg::SLOT_W-1:0]    rd_addr;
  logic [bbhq_pkg::SLOT_W-1:0]    newest_slot;
  logic [bbhq_pkg::SLOT_W-1:0]    append_slot;
  logic                           ring_we;

  // Shared adder
  bbhq_pkg::alu_op_e              alu_op;
  logic [bbhq_pkg::TOTAL_W-1:0]   alu_b;
  bbhq_pkg::alu_res_t             alu_res;

  logic                           accept;
  logic [bbhq_pkg::COUNT_W-1:0]   eff_limit;
  logic                           trunc_more;

  assign accept = start_i && (state_q == bbhq_pkg::ST_IDLE);
  assign busy_o = (state_q != bbhq_pkg::ST_IDLE);
  assign done_o = done_q;
  assign result_o = res_q;

  // Effective limit is the smaller of the register and the ring depth.
  assign eff_limit = (32'(limit_q) > 32'(bbhq_pkg::HISTORY_DEPTH))
                     ? bbhq_pkg::COUNT_W'(bbhq_pkg::HISTORY_DEPTH)
                     : bbhq_pkg::COUNT_W'(limit_q);

  // Slot arithmetic wraps naturally on the slot width.
  assign append_slot = oldest_q + bbhq_pkg::SLOT_W'(held_q);
  assign newest_slot = append_slot - bbhq_pkg::SLOT_W'(1);
  assign rd_addr = ((state_q == bbhq_pkg::ST_FORECAST) || (state_q == bbhq_pkg::ST_TRUNC))
                   ? newest_slot : oldest_q;

  assign trunc_more = (32'(held_q) > (32'(cmd_q.position) + 32'd1));

  bbhq_alu u_alu (
    .op_i     (alu_op),
    .a_i      (total_q),
    .b_i      (alu_b),
    .budget_i (budget_q),
    .res_o    (alu_res)
  );

  // Adder operand select
  always_comb begin
    alu_op = bbhq_pkg::ALU_SUM_CMP;
    alu_b  = '0;
    case (state_q)
      bbhq_pkg::ST_CAP_BUDGET: begin
        alu_b = forecast_q;
      end
      bbhq_pkg::ST_APPEND: begin
        alu_op = bbhq_pkg::ALU_ADD_SAT;
        alu_b  = bbhq_pkg::TOTAL_W'(bbhq_pkg::SIZE_BITS'(cmd_q.entry_bytes));
      end
      bbhq_pkg::ST_DROP: begin
        alu_op = bbhq_pkg::ALU_SUB_FLOOR;
        alu_b  = bbhq_pkg::TOTAL_W'(rd_data_q);
      end
      default: begin
        alu_op = bbhq_pkg::ALU_SUM_CMP;
      end
    endcase
  end

  // Next state: each eviction detours through ST_DROP and returns to its check.
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    case (state_q)
      bbhq_pkg::ST_IDLE: begin
        if (start_i) begin
          case (cmd_i.mode)
            bbhq_pkg::MODE_CAPTURE:  state_d = bbhq_pkg::ST_FORECAST;
            bbhq_pkg::MODE_TRUNCATE: state_d = bbhq_pkg::ST_TRUNC;
            bbhq_pkg::MODE_CHECK:    state_d = bbhq_pkg::ST_DONE;
            default:                 state_d = bbhq_pkg::ST_ENF_LIMIT;
          endcase
        end
      end
      bbhq_pkg::ST_FORECAST: begin
        state_d = bbhq_pkg::ST_FC_LATCH;
      end
      bbhq_pkg::ST_FC_LATCH: begin
        state_d = bbhq_pkg::ST_CAP_BUDGET;
      end
      bbhq_pkg::ST_CAP_BUDGET: begin
        if ((32'(held_q) > 32'd1) && alu_res.over) begin
          ret_d   = bbhq_pkg::ST_CAP_BUDGET;
          state_d = bbhq_pkg::ST_DROP;
        end else begin
          state_d = bbhq_pkg::ST_CAP_LIMIT;
        end
      end
      bbhq_pkg::ST_CAP_LIMIT: begin
        if ((held_q != '0) && (held_q >= eff_limit)) begin
          ret_d   = bbhq_pkg::ST_CAP_LIMIT;
          state_d = bbhq_pkg::ST_DROP;
        end else begin
          state_d = bbhq_pkg::ST_APPEND;
        end
      end
      bbhq_pkg::ST_APPEND: begin
        state_d = bbhq_pkg::ST_ENF_LIMIT;
      end
      bbhq_pkg::ST_ENF_LIMIT: begin
        if (held_q > eff_limit) begin
          ret_d   = bbhq_pkg::ST_ENF_LIMIT;
          state_d = bbhq_pkg::ST_DROP;
        end else begin
          state_d = bbhq_pkg::ST_ENF_BUDGET;
        end
      end
      bbhq_pkg::ST_ENF_BUDGET: begin
        if ((32'(held_q) > 32'd2) && alu_res.over) begin
          ret_d   = bbhq_pkg::ST_ENF_BUDGET;
          state_d = bbhq_pkg::ST_DROP;
        end else begin
          state_d = bbhq_pkg::ST_DONE;
        end
      end
      bbhq_pkg::ST_TRUNC: begin
        if (trunc_more) begin
          ret_d   = bbhq_pkg::ST_TRUNC;
          state_d = bbhq_pkg::ST_DROP;
        end else begin
          state_d = bbhq_pkg::ST_DONE;
        end
      end
      bbhq_pkg::ST_DROP: begin
        state_d = ret_q;
      end
      bbhq_pkg::ST_DONE: begin
        state_d = bbhq_pkg::ST_IDLE;
      end
      default: begin
        state_d = bbhq_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath and result updates per state
  always_comb begin
    oldest_d   = oldest_q;
    held_d     = held_q;
    total_d    = total_q;
    forecast_d = forecast_q;
    done_d     = 1'b0;
    res_d      = res_q;
    ring_we    = 1'b0;
    case (state_q)
      bbhq_pkg::ST_FC_LATCH: begin
        // newest held size; nothing held means no forecast
        forecast_d = (held_q == '0) ? '0 : bbhq_pkg::TOTAL_W'(rd_data_q);
      end
      bbhq_pkg::ST_APPEND: begin
        ring_we = 1'b1;
        held_d  = held_q + bbhq_pkg::COUNT_W'(1);
        total_d = alu_res.value;
      end
      bbhq_pkg::ST_DROP: begin
        total_d = alu_res.value;
        held_d  = held_q - bbhq_pkg::COUNT_W'(1);
        // truncate drops from the newest end, everything else from the oldest
        if (ret_q != bbhq_pkg::ST_TRUNC) begin
          oldest_d = oldest_q + bbhq_pkg::SLOT_W'(1);
        end
      end
      bbhq_pkg::ST_DONE: begin
        done_d            = 1'b1;
        res_d.entry_count = bbhq_pkg::LIMIT_W'(held_q);
        res_d.byte_total  = total_q;
        res_d.new_position = (cmd_q.mode == bbhq_pkg::MODE_CAPTURE)
                             ? bbhq_pkg::POS_W'(held_q - bbhq_pkg::COUNT_W'(1)) : '0;
        res_d.ok = (cmd_q.mode == bbhq_pkg::MODE_CHECK)
                   && (32'(cmd_q.position) < 32'(held_q));
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bbhq_pkg::ST_IDLE;
      ret_q      <= bbhq_pkg::ST_IDLE;
      oldest_q   <= '0;
      held_q     <= '0;
      total_q    <= '0;
      forecast_q <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      ret_q      <= ret_d;
      oldest_q   <= oldest_d;
      held_q     <= held_d;
      total_q    <= total_d;
      forecast_q <= forecast_d;
      done_q     <= done_d;
    end
  end

  // Payload registers hold without reset.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      cmd_q <= cmd_i;
    end
  end

  // Size ring
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_q[append_slot] <= bbhq_pkg::SIZE_BITS'(cmd_q.entry_bytes);
    end
    rd_data_q <= ring_q[rd_addr];
  end

  // Configuration writes; a zero write stores one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= bbhq_pkg::LIMIT_RESET;
      budget_q <= bbhq_pkg::BUDGET_RESET;
    end else if (cfg_we_i) begin
      case (bbhq_pkg::cfg_reg_e'(cfg_idx_i))
        bbhq_pkg::REG_ENTRY_LIMIT: begin
          limit_q <= (cfg_data_i[bbhq_pkg::LIMIT_W-1:0] == '0)
                     ? bbhq_pkg::LIMIT_W'(1) : cfg_data_i[bbhq_pkg::LIMIT_W-1:0];
        end
        bbhq_pkg::REG_BYTE_BUDGET: begin
          budget_q <= (cfg_data_i == '0) ? bbhq_pkg::TOTAL_W'(1) : cfg_data_i;
        end
        default: begin
          limit_q <= limit_q;
        end
      endcase
    end
  end

endmodule

// ----- src/bbhq_alu.sv -----
// Shared 39-bit add/subtract unit: saturating add, floored subtract, budget compare.
module bbhq_alu (
  input  bbhq_pkg::alu_op_e                 op_i,
  input  logic [bbhq_pkg::TOTAL_W-1:0]      a_i,
  input  logic [bbhq_pkg::TOTAL_W-1:0]      b_i,
  input  logic [bbhq_pkg::TOTAL_W-1:0]      budget_i,
  output bbhq_pkg::alu_res_t                res_o
);

  logic                          sub;
  logic [bbhq_pkg::TOTAL_W:0]    b_x;
  logic [bbhq_pkg::TOTAL_W:0]    sum;

  assign sub = (op_i == bbhq_pkg::ALU_SUB_FLOOR);
  assign b_x = sub ? ~{1'b0, b_i} : {1'b0, b_i};
  assign sum = {1'b0, a_i} + b_x + (bbhq_pkg::TOTAL_W + 1)'(sub);

  always_comb begin
    res_o.over = (sum > {1'b0, budget_i});
    case (op_i)
      bbhq_pkg::ALU_ADD_SAT: begin
        // clamp on carry out
        res_o.value = sum[bbhq_pkg::TOTAL_W] ? '1 : sum[bbhq_pkg::TOTAL_W-1:0];
      end
      bbhq_pkg::ALU_SUB_FLOOR: begin
        // top bit set means the difference went negative
        res_o.value = sum[bbhq_pkg::TOTAL_W] ? '0 : sum[bbhq_pkg::TOTAL_W-1:0];
      end
      default: begin
        res_o.value = sum[bbhq_pkg::TOTAL_W-1:0];
      end
    endcase
  end

endmodule

// ----- src/bbhq_checker.sv -----
// Port-level checker for the byte budgeted history queue, with its bind.
module bbhq_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic                 done_i,
  input  bbhq_pkg::result_t    result_i
);

  // An accepted word keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i) |=> busy_i)
    else $error("accepted word did not raise busy");

  // Busy ends only together with a result.
  a_busy_ends_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_i) |-> done_i)
    else $error("busy dropped without a result");

  // Results never come back to back.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |=> !done_i)
    else $error("result strobe held for two cycles");

  // Count stays within depth; a check result carries no captured position.
  a_result_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> ((32'(result_i.entry_count) <= 32'(bbhq_pkg::HISTORY_DEPTH))
                && (!result_i.ok || (result_i.new_position == '0))))
    else $error("result fields inconsistent");

endmodule

bind byte_budgeted_history_queue bbhq_checker u_bbhq_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_i   (busy_o),
  .done_i   (done_o),
  .result_i (result_o)
);
